// ===== hw/rtl/pngd_pkg.sv =====
// ---------------------------------------------------------------------------
// PNG chunk deframer package
// Shared types, constants and the byte-wide CRC-32 update.
// ---------------------------------------------------------------------------
package pngd_pkg;

  // Number of signature bytes skipped at the start of a file (0..8).
  localparam int unsigned SIG_BYTES = 8;

  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } pngd_beat_t;

  // One chunk record.
  typedef struct packed {
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic [31:0] stored_crc;
    logic        crc_bad;
    logic        file_bad;
  } pngd_rec_t;

  // Reflected CRC-32 update over one byte, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/pngd_in_if.sv =====
// ---------------------------------------------------------------------------
// PNG deframer byte channel
// Valid/ready channel carrying one file byte and the start-of-file flag.
// ---------------------------------------------------------------------------
interface pngd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

// ===== hw/rtl/pngd_out_if.sv =====
// ---------------------------------------------------------------------------
// PNG deframer record channel
// Valid/ready channel carrying one chunk record.
// ---------------------------------------------------------------------------
interface pngd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] chunk_type;
  logic [31:0] chunk_length;
  logic [31:0] stored_crc;
  logic        crc_bad;
  logic        file_bad;

  modport source (output valid, output chunk_type, output chunk_length,
                  output stored_crc, output crc_bad, output file_bad, input ready);
  modport sink   (input valid, input chunk_type, input chunk_length,
                  input stored_crc, input crc_bad, input file_bad, output ready);
endinterface

// ===== hw/rtl/pngd_in_stage.sv =====
// ---------------------------------------------------------------------------
// PNG deframer input register
// Holds one accepted beat until the parser consumes it.
// ---------------------------------------------------------------------------
module pngd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  pngd_in_if.sink           in_i,
  input  logic              take_i,
  output logic              valid_o,
  output pngd_pkg::pngd_beat_t beat_o
);
  import pngd_pkg::*;

  logic       valid_q, valid_d;
  pngd_beat_t beat_q;
  logic       fire;

  assign in_i.ready = !valid_q || take_i;
  assign fire       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      beat_q.data_byte     <= in_i.data_byte;
      beat_q.start_of_file <= in_i.start_of_file;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule

// ===== hw/rtl/pngd_parser.sv =====
// ---------------------------------------------------------------------------
// PNG deframer chunk parser
// Field sequencer, data counter and running CRC; flags a record on the
// last CRC byte of each chunk.
// ---------------------------------------------------------------------------
module pngd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  pngd_pkg::pngd_beat_t beat_i,
  output logic                 rec_valid_o,
  output pngd_pkg::pngd_rec_t  rec_o
);
  import pngd_pkg::*;

  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;

  localparam logic [2:0] PhReset  = (SIG_BYTES == 0) ? PH_LEN : PH_SIG;
  localparam logic [3:0] SigBytes = 4'(SIG_BYTES);
  localparam logic [2:0] LastByte = 3'd3;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] scrc_q, scrc_d;
  logic        anybad_q, anybad_d;

  // State as seen by this byte, after a start-of-file restart.
  logic [2:0]  ph;
  logic [2:0]  cnt;
  logic [31:0] rem;
  logic [31:0] len;
  logic [31:0] typ;
  logic [31:0] crc;
  logic [31:0] scrc;
  logic        anybad;
  logic        last;
  logic [31:0] crc_upd;
  logic [31:0] rem_dec;
  logic        bad;
  logic [7:0]  b;

  always_comb begin
    b = beat_i.data_byte;
    if (beat_i.start_of_file) begin
      ph     = PhReset;
      cnt    = 3'd0;
      rem    = 32'd0;
      len    = 32'd0;
      typ    = 32'd0;
      crc    = CRC_PRESET;
      scrc   = 32'd0;
      anybad = 1'b0;
    end else begin
      ph     = phase_q;
      cnt    = cnt_q;
      rem    = rem_q;
      len    = len_q;
      typ    = type_q;
      crc    = crc_q;
      scrc   = scrc_q;
      anybad = anybad_q;
    end

    last    = (cnt == LastByte);
    crc_upd = crc_byte(crc, b);
    rem_dec = rem - 32'd1;
    bad     = ((~crc) != {scrc[23:0], b});

    phase_d     = ph;
    cnt_d       = cnt;
    rem_d       = rem;
    len_d       = len;
    type_d      = typ;
    crc_d       = crc;
    scrc_d      = scrc;
    anybad_d    = anybad;
    rec_valid_o = 1'b0;

    case (ph)
      PH_SIG: begin
        if (({1'b0, cnt} + 4'd1) >= SigBytes) begin
          phase_d = PH_LEN;
          cnt_d   = 3'd0;
        end else begin
          cnt_d = cnt + 3'd1;
        end
      end
      PH_LEN: begin
        len_d = {len[23:0], b};
        if (last) begin
          phase_d = PH_TYPE;
          cnt_d   = 3'd0;
        end else begin
          cnt_d = cnt + 3'd1;
        end
      end
      PH_TYPE: begin
        crc_d  = crc_upd;
        type_d = {typ[23:0], b};
        if (last) begin
          cnt_d   = 3'd0;
          rem_d   = len;
          phase_d = (len != 32'd0) ? PH_DATA : PH_CRC;
        end else begin
          cnt_d = cnt + 3'd1;
        end
      end
      PH_DATA: begin
        crc_d = crc_upd;
        rem_d = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_d = PH_CRC;
          cnt_d   = 3'd0;
        end
      end
      PH_CRC: begin
        scrc_d = {scrc[23:0], b};
        if (!last) begin
          cnt_d = cnt + 3'd1;
        end else begin
          anybad_d    = anybad | bad;
          rec_valid_o = 1'b1;
          phase_d     = PH_LEN;
          cnt_d       = 3'd0;
          crc_d       = CRC_PRESET;
        end
      end
      default: begin
        phase_d = PH_LEN;
        cnt_d   = 3'd0;
      end
    endcase

    rec_o.chunk_type   = typ;
    rec_o.chunk_length = len;
    rec_o.stored_crc   = {scrc[23:0], b};
    rec_o.crc_bad      = bad;
    rec_o.file_bad     = anybad | bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhReset;
      cnt_q    <= 3'd0;
      rem_q    <= 32'd0;
      len_q    <= 32'd0;
      type_q   <= 32'd0;
      crc_q    <= CRC_PRESET;
      scrc_q   <= 32'd0;
      anybad_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      len_q    <= len_d;
      type_q   <= type_d;
      crc_q    <= crc_d;
      scrc_q   <= scrc_d;
      anybad_q <= anybad_d;
    end
  end
endmodule

// ===== hw/rtl/pngd_out_stage.sv =====
// ---------------------------------------------------------------------------
// PNG deframer result register
// Holds one chunk record until the downstream side takes it.
// ---------------------------------------------------------------------------
module pngd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  pngd_pkg::pngd_rec_t rec_i,
  output logic                space_o,
  pngd_out_if.source          out_o
);
  import pngd_pkg::*;

  logic      valid_q, valid_d;
  pngd_rec_t rec_q;

  assign space_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.chunk_type   = rec_q.chunk_type;
  assign out_o.chunk_length = rec_q.chunk_length;
  assign out_o.stored_crc   = rec_q.stored_crc;
  assign out_o.crc_bad      = rec_q.crc_bad;
  assign out_o.file_bad     = rec_q.file_bad;
endmodule

// ===== hw/rtl/png_chunk_deframe_crc_check.sv =====
// ---------------------------------------------------------------------------
// PNG chunk deframer with CRC-32 check
// Parses a PNG byte stream into chunks and reports one record per chunk.
// ---------------------------------------------------------------------------
// The block takes one byte per clock and, stalls aside, sustains that rate
// indefinitely. A byte lands in an input register and is parsed when it steps
// out of it; type and data bytes are folded into the CRC there. A chunk record
// is loaded into the result register as its last CRC byte steps and then
// appears on the output channel. The byte-wide CRC update feeds the running
// CRC register. Raising start_of_file on a byte restarts the parser and the
// file-bad flag with that byte; a chunk cut short produces no record.
module png_chunk_deframe_crc_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  pngd_in_if.sink     byte_i,
  pngd_out_if.source  rec_o
);
  import pngd_pkg::*;

  logic       in_valid;
  pngd_beat_t beat;
  logic       rec_valid;
  pngd_rec_t  rec;
  logic       out_space;
  logic       step;

  // A byte without a record may always move on; one with a record needs room.
  assign step = in_valid && (!rec_valid || out_space);

  pngd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (byte_i),
    .take_i  (step),
    .valid_o (in_valid),
    .beat_o  (beat)
  );

  pngd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .beat_i      (beat),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  pngd_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && rec_valid),
    .rec_i   (rec),
    .space_o (out_space),
    .out_o   (rec_o)
  );
endmodule
